[hw/rtl/gtg_pkg.sv]
// ----------------------------------------------------------------------------
// gtg_pkg: shared types and constants for the go-to-goal steering core
// Fixed-point formats, register indexes, pipeline payload structs and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package gtg_pkg;

  localparam int POS_WIDTH      = 16;
  localparam int HEAD_WIDTH     = 16;
  localparam int DIFF_W         = POS_WIDTH + 1;
  localparam int CW             = 32;  // CORDIC x/y datapath
  localparam int ZW             = 20;  // CORDIC angle accumulator, Q16 rad
  localparam int HW             = HEAD_WIDTH + 1;
  localparam int SPEED_W        = 13;
  localparam int STEER_W        = 8;
  localparam int MAG_W          = 12;
  localparam int ROOT_W         = 16;
  localparam int SQRT_STEPS     = 16;
  localparam int DEF_CORDIC_ITERATIONS = 16;

  // Angle constants in Q12 radians unless noted.
  localparam int ANG_2PI        = 25736;
  localparam int ERR_CLAMP      = 6431;
  localparam int ERR_HALF       = 12861;
  localparam int HALF_PI_Q16    = 102944;

  // Degrees = floor(floor(g * |err| * 28125 / 512) / 62831), reciprocal form.
  localparam int DEG_NUM        = 28125;
  localparam int DEG_SHIFT      = 9;
  localparam int DEG_DIV        = 62831;
  localparam int DEG_SAT        = 31;
  localparam int DEG_SAT_LIMIT  = DEG_SAT * DEG_DIV;
  localparam int DEG_RECIP      = 2187439;
  localparam int DEG_RECIP_SH   = 37;

  // Configuration register port.
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEERING_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED_MAG = 3'd4;

  localparam int DEF_SPEED_GAIN    = 80;
  localparam int DEF_STEERING_GAIN = 16;
  localparam int DEF_STOP_DISTANCE = 30;
  localparam int DEF_REVERSE_LIMIT = 1200;
  localparam int DEF_MIN_SPEED_MAG = 75;

  typedef struct packed {
    logic signed [POS_WIDTH-1:0]  pos_x;
    logic signed [POS_WIDTH-1:0]  pos_y;
    logic signed [POS_WIDTH-1:0]  goal_x;
    logic signed [POS_WIDTH-1:0]  goal_y;
    logic signed [HEAD_WIDTH-1:0] heading;
  } in_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed_cmd;
    logic [STEER_W-1:0]        steering_cmd;
  } out_t;

  typedef struct packed {
    logic [7:0]       steering_gain;
    logic [MAG_W-1:0] reverse_limit;
    logic [MAG_W-1:0] min_speed_mag;
    logic [15:0]      speed_gain_sq;
    logic [31:0]      stop_sq;
    logic [31:0]      lim_sq;
    logic [31:0]      min_sq;
  } cfg_t;

  typedef struct packed {
    logic stop;
    logic over;
    logic under;
  } spd_flags_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
    logic signed [HW-1:0] hn;
    spd_flags_t           flags;
    logic [31:0]          n;
  } prep_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
    logic signed [HW-1:0] hn;
    spd_flags_t           flags;
    logic [31:0]          rem;
    logic [31:0]          root;
  } iter_t;

  function automatic logic signed [ZW-1:0] atan_q16(input int unsigned i);
    case (i)
      0:       atan_q16 = 20'sd51472;
      1:       atan_q16 = 20'sd30386;
      2:       atan_q16 = 20'sd16055;
      3:       atan_q16 = 20'sd8150;
      4:       atan_q16 = 20'sd4091;
      5:       atan_q16 = 20'sd2047;
      6:       atan_q16 = 20'sd1024;
      7:       atan_q16 = 20'sd512;
      8:       atan_q16 = 20'sd256;
      9:       atan_q16 = 20'sd128;
      10:      atan_q16 = 20'sd64;
      11:      atan_q16 = 20'sd32;
      12:      atan_q16 = 20'sd16;
      13:      atan_q16 = 20'sd8;
      14:      atan_q16 = 20'sd4;
      15:      atan_q16 = 20'sd2;
      16:      atan_q16 = 20'sd1;
      default: atan_q16 = 20'sd0;
    endcase
  endfunction

endpackage

[hw/rtl/gtg_prep.sv]
// ----------------------------------------------------------------------------
// gtg_prep: front end of the pipeline
// Forms the goal offset, normalizes the heading, pre-rotates the vector into
// the right half plane and computes the squared distance terms and flags.
// ----------------------------------------------------------------------------
module gtg_prep (
  input  logic          clk,
  input  logic          rst,
  input  gtg_pkg::in_t  in_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  gtg_pkg::cfg_t cfg,
  output gtg_pkg::prep_t out_data,
  output logic          out_valid,
  input  logic          out_ready
);
  import gtg_pkg::*;

  localparam int NS = 6;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v[k] | rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // Stage 0: goal offsets; heading made non-negative.
  logic signed [DIFF_W-1:0] s0_dx, s0_dy;
  logic signed [HW-1:0]     s0_hn;
  logic signed [HW-1:0]     h_ext;

  assign h_ext = {in_data.heading[HEAD_WIDTH-1], in_data.heading};

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_dx <= $signed({in_data.goal_x[POS_WIDTH-1], in_data.goal_x})
             - $signed({in_data.pos_x[POS_WIDTH-1], in_data.pos_x});
      s0_dy <= $signed({in_data.goal_y[POS_WIDTH-1], in_data.goal_y})
             - $signed({in_data.pos_y[POS_WIDTH-1], in_data.pos_y});
      s0_hn <= h_ext[HW-1] ? h_ext + HW'(ANG_2PI) : h_ext;
    end
  end

  // Stage 1: pre-rotation and squares.
  logic signed [CW-1:0]       xe, ye;
  logic signed [2*DIFF_W-1:0] dx2_full, dy2_full;
  prep_t                      s1, s1_next;
  logic [31:0]                s1_dx2, s1_dy2;

  assign xe = {{(CW-DIFF_W-12){s0_dx[DIFF_W-1]}}, s0_dx, 12'b0};
  assign ye = {{(CW-DIFF_W-12){s0_dy[DIFF_W-1]}}, s0_dy, 12'b0};
  assign dx2_full = s0_dx * s0_dx;
  assign dy2_full = s0_dy * s0_dy;

  always_comb begin
    s1_next       = '0;
    s1_next.hn    = s0_hn;
    s1_next.zero  = (s0_dx == '0) && (s0_dy == '0);
    if (xe < 0) begin
      if (ye >= 0) begin
        s1_next.x = ye;
        s1_next.y = -xe;
        s1_next.z = ZW'(HALF_PI_Q16);
      end else begin
        s1_next.x = -ye;
        s1_next.y = xe;
        s1_next.z = -ZW'(HALF_PI_Q16);
      end
    end else begin
      s1_next.x = xe;
      s1_next.y = ye;
      s1_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1     <= s1_next;
      s1_dx2 <= dx2_full[31:0];
      s1_dy2 <= dy2_full[31:0];
    end
  end

  // Stage 2: squared distance.
  prep_t       s2;
  logic [32:0] s2_d2;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2    <= s1;
      s2_d2 <= {1'b0, s1_dx2} + {1'b0, s1_dy2};
    end
  end

  // Stage 3: stop flag, and gain^2 times distance^2 as two partial products.
  prep_t       s3, s3_next;
  logic [32:0] s3_lo;
  logic [31:0] s3_hi;

  always_comb begin
    s3_next            = s2;
    s3_next.flags.stop = s2_d2 < {1'b0, cfg.stop_sq};
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3    <= s3_next;
      s3_lo <= cfg.speed_gain_sq * s2_d2[16:0];
      s3_hi <= cfg.speed_gain_sq * s2_d2[32:17];
    end
  end

  // Stage 4: sum of the partial products.
  prep_t       s4;
  logic [48:0] s4_n;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4   <= s3;
      s4_n <= {s3_hi, 17'b0} + {16'b0, s3_lo};
    end
  end

  // Stage 5: limit compares on the squared magnitude.
  prep_t s5, s5_next;

  always_comb begin
    s5_next             = s4;
    s5_next.flags.over  = s4_n > {17'b0, cfg.lim_sq};
    s5_next.flags.under = (s4_n != '0) && (s4_n < {17'b0, cfg.min_sq});
    s5_next.n           = s4_n[31:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5 <= s5_next;
    end
  end

  assign out_data = s5;

endmodule

[hw/rtl/gtg_iter.sv]
// ----------------------------------------------------------------------------
// gtg_iter: iteration pipeline
// One register stage per step: a vectoring CORDIC rotation for the bearing
// and, alongside it, one digit of the integer square root of the speed term.
// ----------------------------------------------------------------------------
module gtg_iter #(
  parameter int ITERS = gtg_pkg::DEF_CORDIC_ITERATIONS
) (
  input  logic           clk,
  input  logic           rst,
  input  gtg_pkg::prep_t in_data,
  input  logic           in_valid,
  output logic           in_ready,
  output gtg_pkg::iter_t out_data,
  output logic           out_valid,
  input  logic           out_ready
);
  import gtg_pkg::*;

  localparam int NS = (ITERS > SQRT_STEPS) ? ITERS : SQRT_STEPS;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;
  iter_t         st [NS];
  iter_t         head;

  assign rdy[NS] = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];
  assign out_data  = st[NS-1];

  always_comb begin
    head       = '0;
    head.x     = in_data.x;
    head.y     = in_data.y;
    head.z     = in_data.z;
    head.zero  = in_data.zero;
    head.hn    = in_data.hn;
    head.flags = in_data.flags;
    head.rem   = in_data.n;
    head.root  = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    iter_t src, cres, sres;

    assign rdy[k] = !v[k] | rdy[k+1];

    if (k == 0) begin : g_first
      assign src = head;
    end else begin : g_next
      assign src = st[k-1];
    end

    if (k < ITERS) begin : g_cordic
      always_comb begin
        cres = src;
        if (src.y > 0) begin
          cres.x = src.x + (src.y >>> k);
          cres.y = src.y - (src.x >>> k);
          cres.z = src.z + atan_q16(k);
        end else begin
          cres.x = src.x - (src.y >>> k);
          cres.y = src.y + (src.x >>> k);
          cres.z = src.z - atan_q16(k);
        end
      end
    end else begin : g_cordic_pass
      assign cres = src;
    end

    if (k < SQRT_STEPS) begin : g_sqrt
      localparam logic [31:0] BIT = 32'd1 << (30 - 2*k);
      logic [31:0] trial;
      assign trial = cres.root + BIT;
      always_comb begin
        sres = cres;
        if (cres.rem >= trial) begin
          sres.rem  = cres.rem - trial;
          sres.root = (cres.root >> 1) + BIT;
        end else begin
          sres.root = cres.root >> 1;
        end
      end
    end else begin : g_sqrt_pass
      assign sres = cres;
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) st[k] <= sres;
    end
  end

endmodule

[hw/rtl/gtg_post.sv]
// ----------------------------------------------------------------------------
// gtg_post: back end of the pipeline
// Rounds the bearing, forms and limits the heading error, scales it to whole
// degrees for the servo command and selects the speed magnitude.
// ----------------------------------------------------------------------------
module gtg_post (
  input  logic           clk,
  input  logic           rst,
  input  gtg_pkg::iter_t in_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  gtg_pkg::cfg_t  cfg,
  output gtg_pkg::out_t  out_data,
  output logic           out_valid,
  input  logic           out_ready
);
  import gtg_pkg::*;

  localparam int NS = 8;

  typedef struct packed {
    spd_flags_t        flags;
    logic [ROOT_W-1:0] root;
  } spd_t;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v[k] | rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // Stage 0: bearing rounded from Q16 to Q12 and wrapped to 0..2pi.
  logic signed [ZW:0]   zr;
  logic signed [HW-1:0] b_raw;
  logic signed [HW-1:0] q0_b;
  logic signed [HW-1:0] q0_hn;
  spd_t                 q0_s;

  assign zr    = $signed({in_data.z[ZW-1], in_data.z}) + (ZW+1)'(8);
  assign b_raw = HW'(zr >>> 4);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      if (in_data.zero) begin
        q0_b <= '0;
      end else begin
        q0_b <= b_raw[HW-1] ? b_raw + HW'(ANG_2PI) : b_raw;
      end
      q0_hn      <= in_data.hn;
      q0_s.flags <= in_data.flags;
      q0_s.root  <= in_data.root[ROOT_W-1:0];
    end
  end

  // Stage 1: raw heading error.
  logic signed [HW:0] q1_err;
  spd_t               q1_s;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      q1_err <= $signed({q0_b[HW-1], q0_b}) - $signed({q0_hn[HW-1], q0_hn});
      q1_s   <= q0_s;
    end
  end

  // Stage 2: clamp the middle band, wrap the outer band once.
  logic signed [HW:0] q2_err;
  spd_t               q2_s;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      if (q1_err < -(HW+1)'(ERR_CLAMP) && q1_err > -(HW+1)'(ERR_HALF)) begin
        q2_err <= -(HW+1)'(ERR_CLAMP);
      end else if (q1_err > (HW+1)'(ERR_CLAMP) && q1_err < (HW+1)'(ERR_HALF)) begin
        q2_err <= (HW+1)'(ERR_CLAMP);
      end else if (q1_err < -(HW+1)'(ERR_HALF)) begin
        q2_err <= q1_err + (HW+1)'(ANG_2PI);
      end else if (q1_err > (HW+1)'(ERR_HALF)) begin
        q2_err <= q1_err - (HW+1)'(ANG_2PI);
      end else begin
        q2_err <= q1_err;
      end
      q2_s <= q1_s;
    end
  end

  // Stage 3: sign and magnitude of the error.
  logic [13:0] q3_m;
  logic        q3_neg;
  spd_t        q3_s;
  logic signed [HW:0] err_abs;

  assign err_abs = q2_err[HW] ? -q2_err : q2_err;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      q3_m   <= err_abs[13:0];
      q3_neg <= q2_err[HW];
      q3_s   <= q2_s;
    end
  end

  // Stage 4: gain times error.
  logic [21:0] q4_p;
  logic        q4_neg;
  spd_t        q4_s;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      q4_p   <= cfg.steering_gain * q3_m;
      q4_neg <= q3_neg;
      q4_s   <= q3_s;
    end
  end

  // Stage 5: scale toward degrees; flag anything past the saturation point.
  logic [36:0] t_full;
  logic [27:0] a_val;
  logic [20:0] q5_a;
  logic        q5_sat;
  logic        q5_neg;
  spd_t        q5_s;

  assign t_full = q4_p * 15'(DEG_NUM);
  assign a_val  = t_full[36:DEG_SHIFT];

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      q5_a   <= a_val[20:0];
      q5_sat <= a_val >= 28'(DEG_SAT_LIMIT);
      q5_neg <= q4_neg;
      q5_s   <= q4_s;
    end
  end

  // Stage 6: cap, or divide by the degree constant's reciprocal; pick speed.
  logic [42:0]      recip_prod;
  logic [4:0]       q6_deg;
  logic             q6_neg;
  logic [MAG_W-1:0] q6_mag;

  assign recip_prod = q5_a * 22'(DEG_RECIP);

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      q6_deg <= q5_sat ? 5'(DEG_SAT) : recip_prod[DEG_RECIP_SH+4:DEG_RECIP_SH];
      q6_neg <= q5_neg;
      if (q5_s.flags.stop) begin
        q6_mag <= '0;
      end else if (q5_s.flags.over) begin
        q6_mag <= cfg.reverse_limit;
      end else if (q5_s.flags.under) begin
        q6_mag <= cfg.min_speed_mag;
      end else begin
        q6_mag <= q5_s.root[ROOT_W-1:4];
      end
    end
  end

  // Stage 7: servo mapping and output register.
  logic [6:0] dq;
  out_t       q7;

  assign dq = {q6_deg, 1'b0} + {2'b0, q6_deg};

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      if (q6_neg) begin
        q7.steering_cmd <= (dq >= 7'd90) ? 8'd0 : 8'd90 - {1'b0, dq};
      end else begin
        q7.steering_cmd <= (dq >= 7'd90) ? 8'd180 : 8'd90 + {1'b0, dq};
      end
      q7.speed_cmd <= SPEED_W'(0) - $signed({1'b0, q6_mag});
    end
  end

  assign out_data = q7;

endmodule

[hw/rtl/go_to_goal_speed_steering_core.sv]
// ----------------------------------------------------------------------------
// Datapath: gtg_prep, the CORDIC and square-root stages of gtg_iter, then
// gtg_post. Throughput: one transaction per cycle while out_stall is low;
// each stage holds or advances on its own.
// Reset clears all valid bits and restores the default register values.
// ----------------------------------------------------------------------------
// go_to_goal_speed_steering_core: go-to-goal speed and steering controller
// Bearing by pipelined CORDIC, speed from an exact squared-distance path.
// ----------------------------------------------------------------------------
module go_to_goal_speed_steering_core #(
  parameter int CORDIC_ITERATIONS = gtg_pkg::DEF_CORDIC_ITERATIONS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  gtg_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output gtg_pkg::out_t                  out_data,
  input  logic                           cfg_write,
  input  logic [gtg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gtg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gtg_pkg::*;

  logic [7:0]       speed_gain;
  logic [7:0]       steering_gain;
  logic [15:0]      stop_distance;
  logic [MAG_W-1:0] reverse_limit;
  logic [MAG_W-1:0] min_speed_mag;
  logic [15:0]      speed_gain_sq;
  logic [31:0]      stop_sq;
  logic [23:0]      lim_root_sq;
  logic [23:0]      min_root_sq;
  cfg_t             cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_gain    <= 8'(DEF_SPEED_GAIN);
      steering_gain <= 8'(DEF_STEERING_GAIN);
      stop_distance <= 16'(DEF_STOP_DISTANCE);
      reverse_limit <= MAG_W'(DEF_REVERSE_LIMIT);
      min_speed_mag <= MAG_W'(DEF_MIN_SPEED_MAG);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SPEED_GAIN:    speed_gain    <= cfg_data[7:0];
        REG_STEERING_GAIN: steering_gain <= cfg_data[7:0];
        REG_STOP_DISTANCE: stop_distance <= cfg_data[15:0];
        REG_REVERSE_LIMIT: reverse_limit <= cfg_data[MAG_W-1:0];
        REG_MIN_SPEED_MAG: min_speed_mag <= cfg_data[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // Squared gain and thresholds, refreshed in the cycle after a register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_gain_sq <= 16'(DEF_SPEED_GAIN * DEF_SPEED_GAIN);
      stop_sq       <= 32'(DEF_STOP_DISTANCE * DEF_STOP_DISTANCE);
      lim_root_sq   <= 24'(DEF_REVERSE_LIMIT * DEF_REVERSE_LIMIT);
      min_root_sq   <= 24'(DEF_MIN_SPEED_MAG * DEF_MIN_SPEED_MAG);
    end else begin
      speed_gain_sq <= speed_gain * speed_gain;
      stop_sq       <= stop_distance * stop_distance;
      lim_root_sq   <= reverse_limit * reverse_limit;
      min_root_sq   <= min_speed_mag * min_speed_mag;
    end
  end

  always_comb begin
    cfg.steering_gain = steering_gain;
    cfg.reverse_limit = reverse_limit;
    cfg.min_speed_mag = min_speed_mag;
    cfg.speed_gain_sq = speed_gain_sq;
    cfg.stop_sq       = stop_sq;
    cfg.lim_sq        = {lim_root_sq, 8'b0};
    cfg.min_sq        = {min_root_sq, 8'b0};
  end

  prep_t prep_data;
  logic  prep_valid, prep_ready;
  iter_t iter_data;
  logic  iter_valid, iter_ready;
  logic  in_ready;

  assign in_stall = !in_ready;

  gtg_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg       (cfg),
    .out_data  (prep_data),
    .out_valid (prep_valid),
    .out_ready (prep_ready)
  );

  gtg_iter #(
    .ITERS (CORDIC_ITERATIONS)
  ) u_iter (
    .clk       (clk),
    .rst       (rst),
    .in_data   (prep_data),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .out_data  (iter_data),
    .out_valid (iter_valid),
    .out_ready (iter_ready)
  );

  gtg_post u_post (
    .clk       (clk),
    .rst       (rst),
    .in_data   (iter_data),
    .in_valid  (iter_valid),
    .in_ready  (iter_ready),
    .cfg       (cfg),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (!out_stall)
  );

endmodule

[dv/tb_go_to_goal_speed_steering_core.sv]
// ----------------------------------------------------------------------------
// Go-to-goal speed and steering core testbench
// Drives poses through the core under several register settings, predicts
// speed and steering for each accepted transaction and compares the results
// field by field. Random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_go_to_goal_speed_steering_core;
  import gtg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  DRAIN_CYCLES = 60;
  localparam longint ATAN_TBL [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                       256, 128, 64, 32, 16, 8, 4, 2};

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  in_t  in_data;
  out_t out_data;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Copy of the register file used for prediction.
  bit [7:0]  gain_speed = 8'(DEF_SPEED_GAIN);
  bit [7:0]  gain_steer = 8'(DEF_STEERING_GAIN);
  bit [15:0] stop_dist  = 16'(DEF_STOP_DISTANCE);
  bit [11:0] rev_limit  = 12'(DEF_REVERSE_LIMIT);
  bit [11:0] min_mag    = 12'(DEF_MIN_SPEED_MAG);

  out_t expected_cmds[$];
  int   mismatches = 0;
  int   failures = 0;
  int   cycles = 0;
  int   hold_left = 0;
  bit   quiet = 0;

  go_to_goal_speed_steering_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic longint bearing_to_goal(longint dx, longint dy);
    longint x, y, z, nx, ny, b;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    x = dx * 4096;
    y = dy * 4096;
    if (x < 0) begin
      if (y >= 0) begin
        nx = y; ny = -x; z = HALF_PI_Q16;
      end else begin
        nx = -y; ny = x; z = -HALF_PI_Q16;
      end
      x = nx; y = ny;
    end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_TBL[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_TBL[i];
      end
      x = nx; y = ny;
    end
    b = (z + 8) >>> 4;
    if (b < 0) b += ANG_2PI;
    return b;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt >>= 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic out_t predict_cmds(in_t p);
    longint dx, dy, h, err, deg, steer;
    longint unsigned d2, n, lim, mn, mag;
    out_t r;
    dx = longint'(p.goal_x) - longint'(p.pos_x);
    dy = longint'(p.goal_y) - longint'(p.pos_y);
    h = longint'(p.heading);
    if (h < 0) h += ANG_2PI;
    err = bearing_to_goal(dx, dy) - h;
    if (err < -ERR_CLAMP && err > -ERR_HALF) err = -ERR_CLAMP;
    else if (err > ERR_CLAMP && err < ERR_HALF) err = ERR_CLAMP;
    else if (err < -ERR_HALF) err += ANG_2PI;
    else if (err > ERR_HALF) err -= ANG_2PI;
    deg = (longint'(gain_steer) * err * 3600000) / (longint'(16) * 4096 * 62831);
    steer = 90 + deg * 3;
    if (steer < 0) steer = 0;
    if (steer > 180) steer = 180;
    d2 = dx * dx + dy * dy;
    n = longint'(gain_speed) * longint'(gain_speed) * d2;
    lim = 16 * longint'(rev_limit);
    mn = 16 * longint'(min_mag);
    if (d2 < longint'(stop_dist) * longint'(stop_dist)) mag = 0;
    else if (n > lim * lim) mag = 64'(rev_limit);
    else if (n > 0 && n < mn * mn) mag = 64'(min_mag);
    else mag = int_sqrt(n) / 16;
    r.speed_cmd = SPEED_W'(-mag);
    r.steering_cmd = STEER_W'(steer);
    return r;
  endfunction

  // Output side: checks each transaction and drives stall.
  always @(posedge clk) begin
    out_t exp_cmd;
    if (!rst && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        failures++;
        if (mismatches < 10) $display("unexpected output %h", out_data);
        mismatches++;
      end else begin
        exp_cmd = expected_cmds.pop_front();
        if (out_data.speed_cmd !== exp_cmd.speed_cmd ||
            out_data.steering_cmd !== exp_cmd.steering_cmd) begin
          failures++;
          if (mismatches < 10)
            $display("mismatch: speed exp %0d got %0d, steering exp %0d got %0d",
                     exp_cmd.speed_cmd, out_data.speed_cmd,
                     exp_cmd.steering_cmd, out_data.steering_cmd);
          mismatches++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 8);
    end
  end

  task automatic send_pose(in_t p);
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    expected_cmds.push_back(predict_cmds(p));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Each write deasserts cfg_write again before the task returns.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SPEED_GAIN:    gain_speed = val[7:0];
      REG_STEERING_GAIN: gain_steer = val[7:0];
      REG_STOP_DISTANCE: stop_dist = val[15:0];
      REG_REVERSE_LIMIT: rev_limit = val[11:0];
      REG_MIN_SPEED_MAG: min_mag = val[11:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int unsigned sg, int unsigned st, int unsigned sd,
                          int unsigned rl, int unsigned mm);
    wait_idle();
    write_reg(REG_SPEED_GAIN, sg);
    write_reg(REG_STEERING_GAIN, st);
    write_reg(REG_STOP_DISTANCE, sd);
    write_reg(REG_REVERSE_LIMIT, rl);
    write_reg(REG_MIN_SPEED_MAG, mm);
  endtask

  function automatic in_t make_pose(longint px, longint py, longint gx, longint gy,
                                    longint h);
    in_t p;
    p.pos_x = POS_WIDTH'(px);
    p.pos_y = POS_WIDTH'(py);
    p.goal_x = POS_WIDTH'(gx);
    p.goal_y = POS_WIDTH'(gy);
    p.heading = HEAD_WIDTH'(h);
    return p;
  endfunction

  function automatic in_t random_pose();
    in_t p;
    int unsigned kind;
    int unsigned hsel;
    kind = $urandom_range(9);
    p.pos_x = POS_WIDTH'($urandom);
    p.pos_y = POS_WIDTH'($urandom);
    if (kind < 4) begin
      // Short distances stay near the stop, minimum and limit thresholds.
      p.goal_x = p.pos_x + POS_WIDTH'($urandom_range(600) - 300);
      p.goal_y = p.pos_y + POS_WIDTH'($urandom_range(600) - 300);
    end else if (kind == 4) begin
      p.goal_x = p.pos_x;
      p.goal_y = p.pos_y;
    end else begin
      p.goal_x = POS_WIDTH'($urandom);
      p.goal_y = POS_WIDTH'($urandom);
    end
    hsel = $urandom_range(9);
    if (hsel == 0) p.heading = HEAD_WIDTH'($urandom);
    else p.heading = HEAD_WIDTH'(int'($urandom_range(2 * ANG_2PI)) - ANG_2PI);
    return p;
  endfunction

  task automatic test_extremes();
    send_pose(make_pose(0, 0, 0, 0, 0));
    send_pose(make_pose(5, -7, 5, -7, 1000));
    send_pose(make_pose(-32768, -32768, 32767, 32767, 0));
    send_pose(make_pose(32767, 32767, -32768, -32768, ANG_2PI));
    send_pose(make_pose(32767, -32768, -32768, 32767, -ANG_2PI));
    send_pose(make_pose(-32768, 32767, 32767, -32768, -1));
    send_pose(make_pose(0, 0, 100, 0, 32767));
    send_pose(make_pose(0, 0, -100, 0, -32768));
    send_pose(make_pose(0, 0, 0, 100, 0));
    send_pose(make_pose(0, 0, 0, -100, 0));
    send_pose(make_pose(0, 0, 29, 0, 0));
    send_pose(make_pose(0, 0, 30, 0, 0));
    send_pose(make_pose(0, 0, 1, 1, 0));
  endtask

  // Heading errors landing on and just past the clamp and wrap boundaries.
  task automatic test_boundary_errors();
    longint b;
    b = bearing_to_goal(100, 100);
    send_pose(make_pose(0, 0, 100, 100, b + ERR_CLAMP));
    send_pose(make_pose(0, 0, 100, 100, b + ERR_HALF));
    send_pose(make_pose(0, 0, 100, 100, b + ERR_CLAMP + 1));
    b = bearing_to_goal(-100, 100);
    send_pose(make_pose(0, 0, -100, 100, b - ERR_CLAMP));
    b = bearing_to_goal(-100, -100);
    send_pose(make_pose(0, 0, -100, -100, b - ERR_HALF));
    send_pose(make_pose(0, 0, -100, -100, b - ERR_HALF - 1));
    send_pose(make_pose(0, 0, -100, -100, b - ERR_CLAMP - 1));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_pose(random_pose());
  endtask

  task automatic test_register_settings();
    set_regs(0, 0, 0, 0, 0);
    test_extremes();
    test_random(40);
    set_regs(255, 255, 65535, 4095, 4095);
    test_extremes();
    test_random(30);
    set_regs(255, 255, 0, 4095, 0);
    test_random(40);
    // Limit below the minimum magnitude.
    set_regs(40, 200, 10, 50, 300);
    test_random(50);
    set_regs($urandom_range(255), $urandom_range(255), $urandom_range(400),
             $urandom_range(4095), $urandom_range(500));
    test_random(50);
  endtask

  task automatic test_unused_index();
    wait_idle();
    write_reg(REG_UNUSED, 16'hFFFF);
    test_random(20);
  endtask

  // Long output hold-off while poses keep coming with no idling.
  task automatic test_backpressure();
    wait_idle();
    set_regs(DEF_SPEED_GAIN, DEF_STEERING_GAIN, DEF_STOP_DISTANCE,
             DEF_REVERSE_LIMIT, DEF_MIN_SPEED_MAG);
    quiet = 1;
    hold_left = 300;
    test_random(80);
    quiet = 0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_boundary_errors();
    test_random(40);
    test_unused_index();
    test_register_settings();
    test_backpressure();
    wait_idle();
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/gtg_pkg.sv
hw/rtl/gtg_prep.sv
hw/rtl/gtg_iter.sv
hw/rtl/gtg_post.sv
hw/rtl/go_to_goal_speed_steering_core.sv
dv/tb_go_to_goal_speed_steering_core.sv
